>>> rtl/smss_pkg.sv
`timescale 1ns / 1ps

package smss_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned CoilWidth  = 4;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned FullWidth  = 16;
    localparam int unsigned HalfWidth  = 32;

    localparam int unsigned ApbAddrWidth = 4;
    localparam int unsigned ApbDataWidth = 32;

    // Byte offsets of the configuration registers.
    localparam logic [ApbAddrWidth-1:0] ADDR_STEP_MODE  = 4'h0;
    localparam logic [ApbAddrWidth-1:0] ADDR_FULL_PATTS = 4'h4;
    localparam logic [ApbAddrWidth-1:0] ADDR_HALF_PATTS = 4'h8;

    localparam logic [FullWidth-1:0] FULL_PATTS_RESET = 16'd40035;
    localparam logic [HalfWidth-1:0] HALF_PATTS_RESET = 32'd2563007025;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FWD   = 2'd1,
        OP_BACK  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [TimeWidth-1:0]  now_us;
        logic [CountWidth-1:0] step_count;
        logic [TimeWidth-1:0]  step_period;
    } item_t;

    typedef struct packed {
        logic [CoilWidth-1:0]  coil_drive;
        logic [CountWidth-1:0] steps_done;
        logic                  finished;
        logic                  ready_res;
    } result_t;

    typedef struct packed {
        logic                 step_mode;
        logic [FullWidth-1:0] full_step_patterns;
        logic [HalfWidth-1:0] half_step_patterns;
    } cfg_t;

endpackage

>>> rtl/smss_cfg.sv
`timescale 1ns / 1ps

module smss_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smss_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [smss_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [smss_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready,
    output smss_pkg::cfg_t                      cfg
);
    import smss_pkg::*;

    logic                 step_mode_reg;
    logic [FullWidth-1:0] full_patts_reg;
    logic [HalfWidth-1:0] half_patts_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg  <= 1'b0;
            full_patts_reg <= FULL_PATTS_RESET;
            half_patts_reg <= HALF_PATTS_RESET;
        end else if (wr_en) begin
            case ({paddr[ApbAddrWidth-1:2], 2'b00})
                ADDR_STEP_MODE:  step_mode_reg  <= pwdata[0];
                ADDR_FULL_PATTS: full_patts_reg <= pwdata[FullWidth-1:0];
                ADDR_HALF_PATTS: half_patts_reg <= pwdata[HalfWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case ({paddr[ApbAddrWidth-1:2], 2'b00})
            ADDR_STEP_MODE:  prdata = {{(ApbDataWidth-1){1'b0}}, step_mode_reg};
            ADDR_FULL_PATTS: prdata = {{(ApbDataWidth-FullWidth){1'b0}}, full_patts_reg};
            ADDR_HALF_PATTS: prdata = half_patts_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.step_mode          = step_mode_reg;
    assign cfg.full_step_patterns = full_patts_reg;
    assign cfg.half_step_patterns = half_patts_reg;

endmodule

>>> rtl/smss_core.sv
`timescale 1ns / 1ps

module smss_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  smss_pkg::cfg_t    cfg,
    input  logic              advance,
    input  smss_pkg::item_t   item,
    output smss_pkg::result_t result
);
    import smss_pkg::*;

    logic [PhaseWidth-1:0] phase_reg,  phase_next;
    dir_t                  dir_reg,    dir_next;
    logic [CountWidth-1:0] left_reg,   left_next;
    logic [CountWidth-1:0] total_reg,  total_next;
    logic [TimeWidth-1:0]  period_reg, period_next;
    logic [TimeWidth-1:0]  last_reg,   last_next;
    logic [CoilWidth-1:0]  coil_reg,   coil_next;
    logic                  idle_reg,   idle_next;
    logic                  fin;
    logic [TimeWidth-1:0]  elapsed;
    logic [PhaseWidth-1:0] phase_step;
    logic                  due;

    assign elapsed = item.now_us - last_reg;
    assign due     = (dir_reg != DIR_IDLE) && (elapsed > period_reg);

    // Step the phase and wrap it to the current sequence length.
    always_comb begin
        if (dir_reg == DIR_FWD) begin
            phase_step = phase_reg + 1'b1;
        end else begin
            phase_step = phase_reg - 1'b1;
        end
        if (!cfg.step_mode) begin
            phase_step[PhaseWidth-1] = 1'b0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        period_next = period_reg;
        last_next   = last_reg;
        coil_next   = coil_reg;
        idle_next   = idle_reg;
        fin         = 1'b0;
        case (op_t'(item.opcode))
            OP_FWD, OP_BACK: begin
                left_next   = item.step_count;
                total_next  = item.step_count;
                period_next = item.step_period;
                dir_next    = (op_t'(item.opcode) == OP_FWD) ? DIR_FWD : DIR_BACK;
                last_next   = item.now_us;
                idle_next   = 1'b0;
            end
            OP_STOP: begin
                coil_next = '0;
                dir_next  = DIR_IDLE;
                idle_next = 1'b1;
                left_next = '0;
            end
            default: begin
                if (due) begin
                    if (left_reg == '0) begin
                        coil_next = '0;
                        dir_next  = DIR_IDLE;
                        idle_next = 1'b1;
                        fin       = 1'b1;
                    end else begin
                        left_next  = left_reg - 1'b1;
                        last_next  = item.now_us;
                        phase_next = phase_step;
                        if (cfg.step_mode) begin
                            coil_next = cfg.half_step_patterns[{phase_step, 2'b00} +: CoilWidth];
                        end else begin
                            coil_next =
                                cfg.full_step_patterns[{phase_step[1:0], 2'b00} +: CoilWidth];
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            dir_reg    <= DIR_IDLE;
            left_reg   <= '0;
            total_reg  <= '0;
            period_reg <= '0;
            last_reg   <= '0;
            coil_reg   <= '0;
            idle_reg   <= 1'b1;
        end else if (advance) begin
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            period_reg <= period_next;
            last_reg   <= last_next;
            coil_reg   <= coil_next;
            idle_reg   <= idle_next;
        end
    end

    assign result.coil_drive = coil_next;
    assign result.steps_done = total_next - left_next;
    assign result.finished   = fin;
    assign result.ready_res  = idle_next;

    // Idle flag and direction must agree.
    a_idle_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg == (dir_reg == DIR_IDLE))
        else $error("idle flag and direction disagree");

    // Coils stay off whenever no move is active.
    a_idle_coils_off: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg |-> (coil_reg == '0))
        else $error("coils driven while idle");

    // Remaining steps never exceed the loaded count.
    a_left_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= total_reg)
        else $error("steps left above total");

    // A finishing tick leaves the block idle with coils off.
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fin) |=> (idle_reg && (coil_reg == '0)))
        else $error("finish did not go idle");

endmodule

>>> rtl/stepper_motor_step_sequencer.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// s_       | in        | s_tvalid / s_tready   | tuser: opcode; tdata: now, count, period
// m_       | out       | m_tvalid / m_tready   | tlast: finished; tdata: coils, done, ready
// apb      | in        | psel/penable/pready   | step_mode, full and half patterns
//
// Takes one word per cycle while the m_ channel is not stalled; each result
// passes through the input register, then the result register, before it is
// presented.
// The whole move update is one pass of 32-bit subtract, compare and decrement.
// Reset: idle, coils off, pattern registers at their default sequences.
// A stalled m_ channel holds its result; one more word waits in the input
// register, after which s_tready drops until the result is taken.

module stepper_motor_step_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [95:0]                        s_tdata,  // now_us[31:0], step_count[63:32],
                                                         // step_period[95:64]
    input  logic [1:0]                         s_tuser,  // opcode[1:0]
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // coil_drive[3:0], steps_done[35:4],
                                                         // ready_res[36], zero[39:37]
    output logic                               m_tlast,  // finished
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smss_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [smss_pkg::ApbDataWidth-1:0]  pwdata,
    output logic [smss_pkg::ApbDataWidth-1:0]  prdata,
    output logic                               pready
);
    import smss_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    smss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Process the held word when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode      <= s_tuser;
            in_item_reg.now_us      <= s_tdata[31:0];
            in_item_reg.step_count  <= s_tdata[63:32];
            in_item_reg.step_period <= s_tdata[95:64];
        end
    end

    smss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    // Load a new result, or drop the old one once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.ready_res, out_res_reg.steps_done,
                       out_res_reg.coil_drive};
    assign m_tlast  = out_res_reg.finished;

endmodule
